>>> hdl/varint_decoder_top_macros.svh
// Assertion macros for the varint decoder checker.
`ifndef VARINT_DECODER_TOP_MACROS_SVH
`define VARINT_DECODER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define VDEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VDEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/vdec_pkg.sv
// ----------------------------------------------------------------------------
// vdec_pkg
// Types and constants shared by the varint decoder modules.
// ----------------------------------------------------------------------------
package vdec_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned VALUE_W = 64;

  localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
  localparam int unsigned CONT_BIT_POS = 7;

  localparam logic [3:0] MAX_BYTES_32 = 4'd5;
  localparam logic [3:0] MAX_BYTES_64 = 4'd10;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
  localparam logic [1:0] STATUS_STREAM_END = 2'd2;

  localparam logic MODE_32 = 1'b0;
  localparam logic MODE_64 = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              mode;
    logic              stream_end;
  } vdec_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
  } vdec_out_t;

  // What one processed word leaves for the result register.
  typedef struct packed {
    logic      has_result;
    vdec_out_t result;
  } vdec_step_t;

endpackage

>>> hdl/varint_decoder_top.sv
// ----------------------------------------------------------------------------
// varint_decoder_top
// LEB128 varint decoder: takes one stream byte per word and returns one
// result word when a value completes or an error ends it. It accepts one byte
// every cycle while the result side keeps up; a byte passes an input register
// and then the result register, which takes the result of the byte that
// ends its value. The rate is set by the accumulator update, a combinational
// shift-or with the end and length checks. Width is taken from mode on the
// first byte of each value (32-bit: up to 5 bytes, sign-extended from bit 31;
// 64-bit: up to 10 bytes). Status 1 means too long, status 2 means the stream
// ended mid-value; both give value 0.
// ----------------------------------------------------------------------------
module varint_decoder_top
  import vdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  vdec_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output vdec_out_t out_data
);

  logic       s1_valid;
  vdec_in_t   s1_item;
  logic       out_free;
  logic       proc_fire;
  vdec_step_t step;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_free;
  assign proc_fire = s1_valid && out_free;

  vdec_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (proc_fire),
    .item (s1_item),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc_fire && step.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && proc_fire && step.has_result) begin
      out_data <= step.result;
    end
  end

endmodule

>>> hdl/vdec_core.sv
// ----------------------------------------------------------------------------
// vdec_core
// Decode state (accumulator, byte count, latched width) and the per-word
// shift-or, termination and error checks.
// ----------------------------------------------------------------------------
module vdec_core
  import vdec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  vdec_in_t   item,
  output vdec_step_t step
);

  logic [VALUE_W-1:0] acc, acc_next;
  logic [3:0]         cnt, cnt_next;
  logic               wide, wide_next;

  logic               width_eff;
  logic [3:0]         limit;
  logic [3:0]         cnt_inc;
  logic [6:0]         shamt;
  logic [VALUE_W-1:0] acc_sum;
  logic [VALUE_W-1:0] value_ext;

  always_comb begin
    width_eff = (cnt == 4'd0) ? item.mode : wide;
    limit     = (width_eff == MODE_64) ? MAX_BYTES_64 : MAX_BYTES_32;
    cnt_inc   = cnt + 4'd1;
    // 7 * cnt, at most 63
    shamt     = {cnt, 3'b000} - {3'b000, cnt};
    acc_sum   = acc | (VALUE_W'(item.data_byte[6:0] & PAYLOAD_MASK) << shamt[5:0]);
    if (width_eff == MODE_64) begin
      value_ext = acc_sum;
    end else begin
      value_ext = {{(VALUE_W-32){acc_sum[31]}}, acc_sum[31:0]};
    end
  end

  always_comb begin
    step      = '0;
    acc_next  = acc;
    cnt_next  = cnt;
    wide_next = wide;
    if (fire) begin
      acc_next  = '0;
      cnt_next  = 4'd0;
      wide_next = 1'b0;
      priority if (cnt >= limit) begin
        // unreachable count; drop the word and restart
      end else if (!item.data_byte[CONT_BIT_POS]) begin
        step.has_result    = 1'b1;
        step.result.value  = value_ext;
        step.result.status = STATUS_OK;
      end else if (cnt_inc == limit) begin
        step.has_result    = 1'b1;
        step.result.status = STATUS_TOO_LONG;
      end else if (item.stream_end) begin
        step.has_result    = 1'b1;
        step.result.status = STATUS_STREAM_END;
      end else begin
        acc_next  = acc_sum;
        cnt_next  = cnt_inc;
        wide_next = width_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      cnt  <= 4'd0;
      wide <= 1'b0;
    end else begin
      acc  <= acc_next;
      cnt  <= cnt_next;
      wide <= wide_next;
    end
  end

endmodule

>>> hdl/varint_decoder_checker.sv
// ----------------------------------------------------------------------------
// varint_decoder_checker
// Port-level checks on the varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "varint_decoder_top_macros.svh"

module varint_decoder_checker
  import vdec_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input vdec_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input vdec_out_t out_data
);

  `VDEC_ASSERT(a_in_hold,
    in_valid && in_stall |=> in_valid && $stable(in_data),
    "stalled input word changed")
  `VDEC_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "stalled result word changed")
  `VDEC_ASSERT(a_err_zero,
    out_valid && out_data.status != STATUS_OK |-> out_data.value == '0,
    "error word with nonzero value")
  `VDEC_ASSERT(a_no_stall_free,
    !out_valid |-> !in_stall,
    "input stalled with empty result register")
  `VDEC_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid right after reset")

endmodule

bind varint_decoder_top varint_decoder_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
